FILE: hw/rtl/bpc_pkg.sv
// Shared types and constants for the button press classifier.
`default_nettype none

package bpc_pkg;

  localparam int unsigned IdxW    = 2;
  localparam int unsigned MaxBtn  = 1 << IdxW;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgW-1:0] DebounceReset  = 16'd20;
  localparam logic [CfgW-1:0] LongPressReset = 16'd1000;

  localparam logic [CfgIdxW-1:0] CfgDebounce  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgLongPress = 1'b1;

  localparam logic CmdUpdate = 1'b0;
  localparam logic CmdRead   = 1'b1;

  typedef enum logic [2:0] {
    STATUS_IDLE       = 3'd0,
    STATUS_DEBOUNCING = 3'd1,
    STATUS_PRESSED    = 3'd2,
    STATUS_RELEASED   = 3'd3,
    STATUS_LONG_PRESS = 3'd4,
    STATUS_HOLDING    = 3'd5,
    STATUS_LONG_LONG  = 3'd6
  } status_e;

  typedef struct packed {
    status_e          state;
    logic [TimeW-1:0] event_time;
  } button_rec_t;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] long_press_ms;
  } timing_cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bpc_step.sv
// Next-state and status logic for one button transaction.
`default_nettype none

module bpc_step import bpc_pkg::*; (
  input  logic             cmd_i,
  input  logic             pressed_i,
  input  logic [TimeW-1:0] now_ms_i,
  input  timing_cfg_t      cfg_i,
  input  button_rec_t      rec_i,
  output button_rec_t      rec_o,
  output status_e          status_o
);

  logic [TimeW-1:0] elapsed;
  logic             debounce_done;
  logic             long_done;

  assign elapsed       = now_ms_i - rec_i.event_time;
  assign debounce_done = elapsed >= TimeW'(cfg_i.debounce_ms);
  assign long_done     = elapsed >= TimeW'(cfg_i.long_press_ms);

  always_comb begin
    rec_o    = rec_i;
    status_o = rec_i.state;
    if (cmd_i == CmdUpdate) begin
      unique case (rec_i.state)
        STATUS_IDLE: begin
          if (pressed_i) begin
            rec_o.event_time = now_ms_i;
            rec_o.state      = STATUS_DEBOUNCING;
          end
        end
        STATUS_DEBOUNCING: begin
          if (debounce_done) begin
            rec_o.state = STATUS_PRESSED;
          end
        end
        STATUS_PRESSED: begin
          if (!pressed_i) begin
            rec_o.state = STATUS_RELEASED;
          end else if (long_done) begin
            rec_o.event_time = now_ms_i;
            rec_o.state      = STATUS_LONG_PRESS;
          end
        end
        default: begin
        end
      endcase
      status_o = rec_o.state;
    end else begin
      unique case (rec_i.state)
        STATUS_IDLE, STATUS_DEBOUNCING, STATUS_PRESSED: begin
        end
        STATUS_RELEASED: begin
          rec_o.state = STATUS_IDLE;
        end
        default: begin
          // Long press, holding and anything above share one path.
          if (!pressed_i) begin
            rec_o.state = STATUS_IDLE;
          end else if (!long_done) begin
            rec_o.state = STATUS_HOLDING;
          end else begin
            rec_o.event_time = now_ms_i;
            status_o         = STATUS_LONG_LONG;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/button_press_classifier_core.sv
// Top level of the button press classifier: input stage, button store and result stage.
//
// Each input transaction either samples one button's level (cmd 0) or reads and
// consumes its status (cmd 1); every input transaction yields exactly one result
// transaction carrying a 3-bit status, in order.
// The transaction is captured in an input register, its button record is looked
// up and classified there and written back as it leaves, and the status lands in
// the result register. One transaction can be accepted every cycle while the
// receiver keeps out_ready_i high.
// The button store is updated by a single read-modify-write, so consecutive
// transactions on the same button see each other's updates.
// When the receiver holds out_ready_i low, the result is kept, one further
// transaction is held in the input register, and in_ready_o then drops.
// The configuration channel is always ready; it must only be written while no
// transaction is in flight. Reset returns every button to idle with a zero
// timestamp and restores the debounce and long-press times to 20 ms and 1000 ms.
`default_nettype none

module button_press_classifier_core import bpc_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [IdxW-1:0]    button_index_i,
  input  logic               pressed_i,
  input  logic [TimeW-1:0]   now_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam int unsigned NumSlots = (NUM_BUTTONS < MaxBtn) ? NUM_BUTTONS : MaxBtn;

  logic             s1_valid_q;
  logic             s1_cmd_q;
  logic [IdxW-1:0]  s1_index_q;
  logic             s1_pressed_q;
  logic [TimeW-1:0] s1_now_q;

  logic        out_valid_q;
  status_e     status_q;
  status_e     status_d;

  timing_cfg_t cfg_q;
  button_rec_t slot_q [NumSlots];

  logic        advance;
  logic        s1_hit;
  button_rec_t sel_rec;
  button_rec_t new_rec;
  status_e     step_status;

  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign s1_hit      = 32'(s1_index_q) < NUM_BUTTONS;

  always_comb begin
    sel_rec = '{state: STATUS_IDLE, event_time: '0};
    for (int i = 0; i < NumSlots; i++) begin
      if (s1_index_q == IdxW'(i)) begin
        sel_rec = slot_q[i];
      end
    end
  end

  bpc_step u_step (
    .cmd_i     (s1_cmd_q),
    .pressed_i (s1_pressed_q),
    .now_ms_i  (s1_now_q),
    .cfg_i     (cfg_q),
    .rec_i     (sel_rec),
    .rec_o     (new_rec),
    .status_o  (step_status)
  );

  assign status_d = s1_hit ? step_status : STATUS_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_cmd_q     <= cmd_i;
      s1_index_q   <= button_index_i;
      s1_pressed_q <= pressed_i;
      s1_now_q     <= now_ms_i;
    end
    if (advance) begin
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSlots; i++) begin
        slot_q[i] <= '{state: STATUS_IDLE, event_time: '0};
      end
    end else if (advance && s1_hit) begin
      for (int i = 0; i < NumSlots; i++) begin
        if (s1_index_q == IdxW'(i)) begin
          slot_q[i] <= new_rec;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{debounce_ms: DebounceReset, long_press_ms: LongPressReset};
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgDebounce:  cfg_q.debounce_ms   <= cfg_data_i;
        CfgLongPress: cfg_q.long_press_ms <= cfg_data_i;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("Input stalled without a full pipeline and a stalled receiver.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !s1_hit |=> status_q == STATUS_IDLE)
    else $error("Out-of-range button did not report idle.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance))
    else $error("Result appeared without a transaction leaving the input stage.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_cmd_q == CmdRead && s1_hit && sel_rec.state == STATUS_RELEASED
      |=> status_q == STATUS_RELEASED)
    else $error("Read of a released button did not report released.");

endmodule

`default_nettype wire
